@@ rtl/xkcp_pkg.sv @@
// Shared constants, codes and types of the XOR k-closest peer table.
package xkcp_pkg;

   localparam int TABLE_DEPTH    = 64;
   localparam int K_MAX          = 20;
   localparam int ID_BITS        = 16;
   localparam int ADDR_BITS      = 10;
   localparam int K_BEST_BITS    = 5;
   localparam int KIND_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = (ID_BITS > K_BEST_BITS) ? ID_BITS : K_BEST_BITS;

   localparam int SLOT_BITS  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SCAN_BITS  = $clog2(TABLE_DEPTH + 1);
   localparam int KIDX_BITS  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int KCNT_BITS  = $clog2(K_MAX + 1);
   localparam int ENTRY_BITS = ID_BITS + ADDR_BITS;

   localparam logic [K_BEST_BITS-1:0] K_BEST_RESET = K_BEST_BITS'(20);

   localparam logic [KIND_BITS-1:0] KIND_INSERT = KIND_BITS'(0);
   localparam logic [KIND_BITS-1:0] KIND_ERASE  = KIND_BITS'(1);
   localparam logic [KIND_BITS-1:0] KIND_QUERY  = KIND_BITS'(2);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_K_BEST  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SELF_ID = CSR_INDEX_BITS'(1);

   typedef enum logic [2:0] {
      STAT_PEER     = 3'd0,
      STAT_INSERTED = 3'd1,
      STAT_UPDATED  = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_ERASED   = 3'd4,
      STAT_MISS     = 3'd5,
      STAT_EMPTY    = 3'd6,
      STAT_SELF     = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH,
      S_FETCH,
      S_LOAD,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic push;
   } topk_ctl_type;

endpackage

@@ rtl/xkcp_if.sv @@
// Channel interfaces of the XOR k-closest peer table.
interface xkcp_req_if;
   logic                                valid;
   logic                                ready;
   logic [xkcp_pkg::KIND_BITS-1:0]      kind;
   logic [xkcp_pkg::ID_BITS-1:0]        peer_id;
   logic [xkcp_pkg::ADDR_BITS-1:0]      peer_addr;
   logic [xkcp_pkg::ID_BITS-1:0]        key;
   modport source (output valid, kind, peer_id, peer_addr, key, input ready);
   modport sink   (input valid, kind, peer_id, peer_addr, key, output ready);
endinterface

interface xkcp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [xkcp_pkg::ID_BITS-1:0]        result_id;
   logic [xkcp_pkg::ADDR_BITS-1:0]      result_addr;
   logic [xkcp_pkg::ID_BITS-1:0]        result_distance;
   logic [2:0]                          status;
   logic                                last;
   modport source (output valid, result_id, result_addr, result_distance, status, last,
                   input ready);
   modport sink   (input valid, result_id, result_addr, result_distance, status, last,
                   output ready);
endinterface

interface xkcp_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [xkcp_pkg::CSR_INDEX_BITS-1:0]    index;
   logic [xkcp_pkg::CSR_DATA_BITS-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/xkcp_topk.sv @@
// Sorted list of the closest distances seen during a query scan.
module xkcp_topk (
   input  logic                             clock,
   input  logic                             reset,
   input  xkcp_pkg::topk_ctl_type           ctl,
   input  logic [xkcp_pkg::KCNT_BITS-1:0]   k_eff,
   input  logic [xkcp_pkg::ID_BITS-1:0]     push_dist,
   input  logic [xkcp_pkg::SLOT_BITS-1:0]   push_slot,
   input  logic [xkcp_pkg::KIDX_BITS-1:0]   sel_idx,
   output logic [xkcp_pkg::KCNT_BITS-1:0]   count,
   output logic [xkcp_pkg::ID_BITS-1:0]     sel_dist,
   output logic [xkcp_pkg::SLOT_BITS-1:0]   sel_slot
);

   logic [xkcp_pkg::ID_BITS-1:0]   dist_ff [xkcp_pkg::K_MAX];
   logic [xkcp_pkg::SLOT_BITS-1:0] slot_ff [xkcp_pkg::K_MAX];
   logic [xkcp_pkg::ID_BITS-1:0]   dist_in [xkcp_pkg::K_MAX];
   logic [xkcp_pkg::SLOT_BITS-1:0] slot_in [xkcp_pkg::K_MAX];
   logic [xkcp_pkg::K_MAX-1:0]     worse;
   logic [xkcp_pkg::KCNT_BITS-1:0] count_ff;

   // An entry moves down when it is empty or farther than the new distance.
   always_comb begin
      for (int i = 0; i < xkcp_pkg::K_MAX; i++) begin
         worse[i] = (i >= int'(count_ff)) || (dist_ff[i] > push_dist);
      end
      for (int i = 0; i < xkcp_pkg::K_MAX; i++) begin
         dist_in[i] = dist_ff[i];
         slot_in[i] = slot_ff[i];
         if (worse[i]) begin
            if (i > 0 && worse[(i > 0) ? i - 1 : 0]) begin
               dist_in[i] = dist_ff[(i > 0) ? i - 1 : 0];
               slot_in[i] = slot_ff[(i > 0) ? i - 1 : 0];
            end else begin
               dist_in[i] = push_dist;
               slot_in[i] = push_slot;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         for (int i = 0; i < xkcp_pkg::K_MAX; i++) begin
            dist_ff[i] <= dist_in[i];
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctl.clear) begin
         count_ff <= '0;
      end else if (ctl.push && count_ff < k_eff) begin
         count_ff <= count_ff + xkcp_pkg::KCNT_BITS'(1);
      end
   end

   assign count    = count_ff;
   assign sel_dist = dist_ff[sel_idx];
   assign sel_slot = slot_ff[sel_idx];

endmodule

@@ rtl/xor_k_closest_peer_table.sv @@
// Top level of the XOR k-closest peer table.
// An insert, an erase or a query walks the whole peer table through its single read port,
// one slot per clock. An insert, an erase or a query of an empty table then passes a finish
// step, which loads the result register, and presents its result in the emit step. A query
// that finds peers goes from the finish step through a fetch step, which rereads the table
// at the first peer's slot, and a load step before it presents that peer, and each further
// peer repeats the fetch and load steps after the one before it is taken. An insert of the
// own identifier presents its result on the next cycle, and an unknown kind is taken without
// any result. The request channel is ready only while the block is idle; the configuration
// channel is always ready and must be written only while idle.
module xor_k_closest_peer_table (
   input  logic        clock,
   input  logic        reset,
   xkcp_req_if.sink    req_ch,
   xkcp_rsp_if.source  rsp_ch,
   xkcp_csr_if.sink    csr_ch
);

   xkcp_pkg::state_type state_ff, state_in;

   logic [xkcp_pkg::K_BEST_BITS-1:0] k_best_ff;
   logic [xkcp_pkg::ID_BITS-1:0]     self_id_ff;
   logic [xkcp_pkg::KCNT_BITS-1:0]   k_eff;

   logic [xkcp_pkg::KIND_BITS-1:0]   kind_ff;
   logic [xkcp_pkg::ID_BITS-1:0]     pid_ff;
   logic [xkcp_pkg::ADDR_BITS-1:0]   paddr_ff;
   logic [xkcp_pkg::ID_BITS-1:0]     key_ff;

   logic [xkcp_pkg::ENTRY_BITS-1:0]  table_mem [xkcp_pkg::TABLE_DEPTH];
   logic [xkcp_pkg::ENTRY_BITS-1:0]  rd_data_ff;
   logic [xkcp_pkg::TABLE_DEPTH-1:0] table_valid_ff;
   logic [xkcp_pkg::SLOT_BITS-1:0]   mem_rd_addr;
   logic [xkcp_pkg::SLOT_BITS-1:0]   mem_wr_addr;
   logic                             mem_we;

   logic [xkcp_pkg::SCAN_BITS-1:0]   scan_cnt_ff;
   logic                             pipe_valid_ff;
   logic [xkcp_pkg::SLOT_BITS-1:0]   pipe_slot_ff;
   logic                             match_ff;
   logic [xkcp_pkg::SLOT_BITS-1:0]   match_slot_ff;
   logic                             free_ff;
   logic [xkcp_pkg::SLOT_BITS-1:0]   free_slot_ff;
   logic [xkcp_pkg::KIDX_BITS-1:0]   emit_idx_ff;

   logic [xkcp_pkg::ID_BITS-1:0]     out_id_ff;
   logic [xkcp_pkg::ADDR_BITS-1:0]   out_addr_ff;
   logic [xkcp_pkg::ID_BITS-1:0]     out_dist_ff;
   xkcp_pkg::status_type             out_status_ff;
   logic                             out_last_ff;

   logic                             req_fire;
   logic                             rsp_fire;
   logic                             is_self;
   logic                             scan_issue;
   logic                             scan_last;
   logic                             proc_valid;
   logic [xkcp_pkg::ID_BITS-1:0]     proc_id;
   logic [xkcp_pkg::ID_BITS-1:0]     rd_id;
   logic [xkcp_pkg::ADDR_BITS-1:0]   rd_addr;

   xkcp_pkg::topk_ctl_type           topk_ctl;
   logic [xkcp_pkg::KCNT_BITS-1:0]   topk_count;
   logic [xkcp_pkg::ID_BITS-1:0]     topk_dist;
   logic [xkcp_pkg::SLOT_BITS-1:0]   topk_slot;

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_best_ff  <= xkcp_pkg::K_BEST_RESET;
         self_id_ff <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            xkcp_pkg::CSR_K_BEST:  k_best_ff  <= csr_ch.data[xkcp_pkg::K_BEST_BITS-1:0];
            xkcp_pkg::CSR_SELF_ID: self_id_ff <= csr_ch.data[xkcp_pkg::ID_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (k_best_ff == '0) begin
         k_eff = xkcp_pkg::KCNT_BITS'(1);
      end else if (int'(k_best_ff) > xkcp_pkg::K_MAX) begin
         k_eff = xkcp_pkg::KCNT_BITS'(xkcp_pkg::K_MAX);
      end else begin
         k_eff = xkcp_pkg::KCNT_BITS'(k_best_ff);
      end
   end

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign rsp_fire   = rsp_ch.valid && rsp_ch.ready;
   assign is_self    = (req_ch.kind == xkcp_pkg::KIND_INSERT) && (req_ch.peer_id == self_id_ff);
   assign scan_issue = (state_ff == xkcp_pkg::S_SCAN) &&
                       (scan_cnt_ff < xkcp_pkg::SCAN_BITS'(xkcp_pkg::TABLE_DEPTH));
   assign scan_last  = (state_ff == xkcp_pkg::S_SCAN) && pipe_valid_ff &&
                       (scan_cnt_ff == xkcp_pkg::SCAN_BITS'(xkcp_pkg::TABLE_DEPTH));
   assign rd_id      = rd_data_ff[xkcp_pkg::ADDR_BITS +: xkcp_pkg::ID_BITS];
   assign rd_addr    = rd_data_ff[xkcp_pkg::ADDR_BITS-1:0];
   assign proc_id    = rd_id;
   assign proc_valid = table_valid_ff[pipe_slot_ff];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         xkcp_pkg::S_IDLE: begin
            if (req_fire) begin
               if (is_self) begin
                  state_in = xkcp_pkg::S_EMIT;
               end else if (req_ch.kind == xkcp_pkg::KIND_INSERT ||
                            req_ch.kind == xkcp_pkg::KIND_ERASE ||
                            req_ch.kind == xkcp_pkg::KIND_QUERY) begin
                  state_in = xkcp_pkg::S_SCAN;
               end
            end
         end
         xkcp_pkg::S_SCAN: begin
            if (scan_last) state_in = xkcp_pkg::S_FINISH;
         end
         xkcp_pkg::S_FINISH: begin
            if (kind_ff == xkcp_pkg::KIND_QUERY && topk_count != '0) begin
               state_in = xkcp_pkg::S_FETCH;
            end else begin
               state_in = xkcp_pkg::S_EMIT;
            end
         end
         xkcp_pkg::S_FETCH: state_in = xkcp_pkg::S_LOAD;
         xkcp_pkg::S_LOAD:  state_in = xkcp_pkg::S_EMIT;
         xkcp_pkg::S_EMIT: begin
            if (rsp_fire) begin
               state_in = out_last_ff ? xkcp_pkg::S_IDLE : xkcp_pkg::S_FETCH;
            end
         end
         default: state_in = xkcp_pkg::S_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_ch.ready  = (state_ff == xkcp_pkg::S_IDLE);
      rsp_ch.valid  = (state_ff == xkcp_pkg::S_EMIT);
      mem_rd_addr   = (state_ff == xkcp_pkg::S_FETCH) ? topk_slot :
                      scan_cnt_ff[xkcp_pkg::SLOT_BITS-1:0];
      mem_we        = (state_ff == xkcp_pkg::S_FINISH) &&
                      (kind_ff == xkcp_pkg::KIND_INSERT) && (match_ff || free_ff);
      mem_wr_addr   = match_ff ? match_slot_ff : free_slot_ff;
      topk_ctl.clear = (state_ff == xkcp_pkg::S_IDLE) && req_fire &&
                       (req_ch.kind == xkcp_pkg::KIND_QUERY);
      topk_ctl.push  = (state_ff == xkcp_pkg::S_SCAN) && pipe_valid_ff &&
                       (kind_ff == xkcp_pkg::KIND_QUERY) && proc_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xkcp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Peer table storage with a registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_wr_addr] <= {pid_ff, paddr_ff};
      end
      rd_data_ff <= table_mem[mem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_valid_ff <= '0;
      end else if (state_ff == xkcp_pkg::S_FINISH) begin
         if (kind_ff == xkcp_pkg::KIND_INSERT && !match_ff && free_ff) begin
            table_valid_ff[free_slot_ff] <= 1'b1;
         end
         if (kind_ff == xkcp_pkg::KIND_ERASE && match_ff) begin
            table_valid_ff[match_slot_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= scan_issue;
      end
   end

   // Request capture and table walk.
   always_ff @(posedge clock) begin
      if (state_ff == xkcp_pkg::S_IDLE && req_fire) begin
         kind_ff     <= req_ch.kind;
         pid_ff      <= req_ch.peer_id;
         paddr_ff    <= req_ch.peer_addr;
         key_ff      <= req_ch.key;
         scan_cnt_ff <= '0;
         match_ff    <= 1'b0;
         free_ff     <= 1'b0;
      end else if (state_ff == xkcp_pkg::S_SCAN) begin
         if (scan_issue) begin
            scan_cnt_ff  <= scan_cnt_ff + xkcp_pkg::SCAN_BITS'(1);
            pipe_slot_ff <= scan_cnt_ff[xkcp_pkg::SLOT_BITS-1:0];
         end
         if (pipe_valid_ff) begin
            if (proc_valid && proc_id == pid_ff) begin
               match_ff      <= 1'b1;
               match_slot_ff <= pipe_slot_ff;
            end
            if (!proc_valid && !free_ff) begin
               free_ff      <= 1'b1;
               free_slot_ff <= pipe_slot_ff;
            end
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (state_ff == xkcp_pkg::S_IDLE && req_fire && is_self) begin
         out_id_ff     <= req_ch.peer_id;
         out_addr_ff   <= req_ch.peer_addr;
         out_dist_ff   <= '0;
         out_status_ff <= xkcp_pkg::STAT_SELF;
         out_last_ff   <= 1'b1;
      end else if (state_ff == xkcp_pkg::S_FINISH) begin
         out_id_ff   <= pid_ff;
         out_addr_ff <= '0;
         out_dist_ff <= '0;
         out_last_ff <= 1'b1;
         emit_idx_ff <= '0;
         unique case (kind_ff)
            xkcp_pkg::KIND_INSERT: begin
               out_addr_ff <= paddr_ff;
               if (match_ff) begin
                  out_status_ff <= xkcp_pkg::STAT_UPDATED;
               end else if (free_ff) begin
                  out_status_ff <= xkcp_pkg::STAT_INSERTED;
               end else begin
                  out_status_ff <= xkcp_pkg::STAT_FULL;
               end
            end
            xkcp_pkg::KIND_ERASE: begin
               out_status_ff <= match_ff ? xkcp_pkg::STAT_ERASED : xkcp_pkg::STAT_MISS;
            end
            default: begin
               out_id_ff     <= '0;
               out_status_ff <= xkcp_pkg::STAT_EMPTY;
            end
         endcase
      end else if (state_ff == xkcp_pkg::S_LOAD) begin
         out_id_ff     <= rd_id;
         out_addr_ff   <= rd_addr;
         out_dist_ff   <= topk_dist;
         out_status_ff <= xkcp_pkg::STAT_PEER;
         out_last_ff   <= (xkcp_pkg::KCNT_BITS'(emit_idx_ff) + xkcp_pkg::KCNT_BITS'(1)) ==
                          topk_count;
      end else if (state_ff == xkcp_pkg::S_EMIT && rsp_fire && !out_last_ff) begin
         emit_idx_ff <= emit_idx_ff + xkcp_pkg::KIDX_BITS'(1);
      end
   end

   assign rsp_ch.result_id       = out_id_ff;
   assign rsp_ch.result_addr     = out_addr_ff;
   assign rsp_ch.result_distance = out_dist_ff;
   assign rsp_ch.status          = out_status_ff;
   assign rsp_ch.last            = out_last_ff;

   xkcp_topk u_topk (
      .clock     (clock),
      .reset     (reset),
      .ctl       (topk_ctl),
      .k_eff     (k_eff),
      .push_dist (proc_id ^ key_ff),
      .push_slot (pipe_slot_ff),
      .sel_idx   (emit_idx_ff),
      .count     (topk_count),
      .sel_dist  (topk_dist),
      .sel_slot  (topk_slot)
   );

   a_write_only_at_finish: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == xkcp_pkg::S_FINISH))
      else $error("table written outside the finish step");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && out_last_ff) |=> (state_ff == xkcp_pkg::S_IDLE))
      else $error("block did not return to idle after the final result");

   a_peer_within_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && out_status_ff == xkcp_pkg::STAT_PEER) |->
         (xkcp_pkg::KCNT_BITS'(emit_idx_ff) < topk_count && topk_count <= k_eff))
      else $error("query result index beyond the closest list");

   a_scan_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == xkcp_pkg::S_SCAN) |->
         (scan_cnt_ff <= xkcp_pkg::SCAN_BITS'(xkcp_pkg::TABLE_DEPTH)))
      else $error("scan counter ran past the table");

endmodule

@@ tb/tb_xor_k_closest_peer_table.sv @@
// Self-checking testbench of the XOR k-closest peer table, with directed and random traffic.
`timescale 1ns / 1ps

module tb_xor_k_closest_peer_table;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 120;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int POOL_SIZE      = 128;

   localparam logic [xkcp_pkg::KIND_BITS-1:0]      KIND_NONE   = xkcp_pkg::KIND_BITS'(3);
   localparam logic [xkcp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_2 = xkcp_pkg::CSR_INDEX_BITS'(2);
   localparam logic [xkcp_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_3 = xkcp_pkg::CSR_INDEX_BITS'(3);

   typedef struct packed {
      logic [xkcp_pkg::KIND_BITS-1:0] kind;
      logic [xkcp_pkg::ID_BITS-1:0]   peer_id;
      logic [xkcp_pkg::ADDR_BITS-1:0] peer_addr;
      logic [xkcp_pkg::ID_BITS-1:0]   key;
   } peer_op_type;

   typedef struct packed {
      logic [xkcp_pkg::ID_BITS-1:0]   id;
      logic [xkcp_pkg::ADDR_BITS-1:0] addr;
      logic [xkcp_pkg::ID_BITS-1:0]   distance;
      xkcp_pkg::status_type           status;
      logic                           last;
   } peer_result_type;

   typedef struct packed {
      peer_op_type     op;
      logic            typed;
      peer_result_type result;
   } directed_row_type;

   logic clock;
   logic reset;

   xkcp_req_if req_ch ();
   xkcp_rsp_if rsp_ch ();
   xkcp_csr_if csr_ch ();

   xor_k_closest_peer_table dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   logic [xkcp_pkg::ID_BITS-1:0]     peer_ids   [xkcp_pkg::TABLE_DEPTH];
   logic [xkcp_pkg::ADDR_BITS-1:0]   peer_addrs [xkcp_pkg::TABLE_DEPTH];
   logic                             peer_live  [xkcp_pkg::TABLE_DEPTH];
   logic [xkcp_pkg::K_BEST_BITS-1:0] k_best_reg;
   logic [xkcp_pkg::ID_BITS-1:0]     self_id_reg;

   peer_result_type              due_results [$];
   directed_row_type             directed_rows [$];
   logic [xkcp_pkg::ID_BITS-1:0] id_pool [POOL_SIZE];

   int unsigned fail_count;
   int unsigned results_checked;
   int unsigned ops_accepted;
   int unsigned status_seen [8];
   int unsigned req_gap_pct;
   int unsigned rsp_stall_pct;
   logic        holdoff_req;
   logic        rsp_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic predict_peer_results(input peer_op_type op, ref peer_result_type outs[$]);
      int                           slot;
      int                           k;
      int                           pick;
      logic [xkcp_pkg::ID_BITS-1:0] xor_dist;
      logic [xkcp_pkg::ID_BITS-1:0] floor_dist;
      logic [xkcp_pkg::ID_BITS-1:0] best;
      peer_result_type              r;
      outs.delete();
      slot = -1;
      best = '0;
      for (int s = 0; s < xkcp_pkg::TABLE_DEPTH; s++)
         if (slot < 0 && peer_live[s] && peer_ids[s] == op.peer_id) slot = s;
      case (op.kind)
         xkcp_pkg::KIND_INSERT: begin
            r = '{op.peer_id, op.peer_addr, '0, xkcp_pkg::STAT_INSERTED, 1'b1};
            if (op.peer_id == self_id_reg) begin
               r.status = xkcp_pkg::STAT_SELF;
            end else if (slot >= 0) begin
               peer_addrs[slot] = op.peer_addr;
               r.status = xkcp_pkg::STAT_UPDATED;
            end else begin
               r.status = xkcp_pkg::STAT_FULL;
               for (int s = 0; s < xkcp_pkg::TABLE_DEPTH; s++) begin
                  if (r.status == xkcp_pkg::STAT_FULL && !peer_live[s]) begin
                     peer_live[s]  = 1'b1;
                     peer_ids[s]   = op.peer_id;
                     peer_addrs[s] = op.peer_addr;
                     r.status      = xkcp_pkg::STAT_INSERTED;
                  end
               end
            end
            outs.insert(outs.size(), r);
         end
         xkcp_pkg::KIND_ERASE: begin
            r = '{op.peer_id, '0, '0, xkcp_pkg::STAT_MISS, 1'b1};
            if (slot >= 0) begin
               peer_live[slot] = 1'b0;
               r.status = xkcp_pkg::STAT_ERASED;
            end
            outs.insert(outs.size(), r);
         end
         xkcp_pkg::KIND_QUERY: begin
            k = (k_best_reg == 0) ? 1 :
                ((k_best_reg > xkcp_pkg::K_MAX) ? xkcp_pkg::K_MAX : int'(k_best_reg));
            floor_dist = '0;
            for (int n = 0; n < k; n++) begin
               pick = -1;
               for (int s = 0; s < xkcp_pkg::TABLE_DEPTH; s++) begin
                  if (peer_live[s]) begin
                     xor_dist = peer_ids[s] ^ op.key;
                     if ((n == 0 || xor_dist > floor_dist) && (pick < 0 || xor_dist < best)) begin
                        pick = s;
                        best = xor_dist;
                     end
                  end
               end
               if (pick < 0) break;
               r = '{peer_ids[pick], peer_addrs[pick], best, xkcp_pkg::STAT_PEER, 1'b0};
               outs.insert(outs.size(), r);
               floor_dist = best;
            end
            if (outs.size() == 0) begin
               r = '{'0, '0, '0, xkcp_pkg::STAT_EMPTY, 1'b1};
               outs.insert(outs.size(), r);
            end else begin
               outs[outs.size()-1].last = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_op(input peer_op_type op, input logic typed,
                          input peer_result_type typed_result);
      peer_result_type outs [$];
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 100)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.kind      <= op.kind;
      req_ch.peer_id   <= op.peer_id;
      req_ch.peer_addr <= op.peer_addr;
      req_ch.key       <= op.key;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      ops_accepted++;
      predict_peer_results(op, outs);
      if (typed) due_results.insert(due_results.size(), typed_result);
      else foreach (outs[i]) due_results.insert(due_results.size(), outs[i]);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [xkcp_pkg::CSR_INDEX_BITS-1:0] reg_index,
                            input logic [xkcp_pkg::CSR_DATA_BITS-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= reg_index;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      if (reg_index == xkcp_pkg::CSR_K_BEST) k_best_reg = data[xkcp_pkg::K_BEST_BITS-1:0];
      else if (reg_index == xkcp_pkg::CSR_SELF_ID) self_id_reg = data[xkcp_pkg::ID_BITS-1:0];
   endtask

   task automatic configure(input logic [xkcp_pkg::K_BEST_BITS-1:0] k,
                            input logic [xkcp_pkg::ID_BITS-1:0] self_id,
                            input logic spare);
      logic [xkcp_pkg::CSR_DATA_BITS-1:0] data;
      data = xkcp_pkg::CSR_DATA_BITS'($urandom);
      data[xkcp_pkg::K_BEST_BITS-1:0] = k;
      csr_write(xkcp_pkg::CSR_K_BEST, data);
      csr_write(xkcp_pkg::CSR_SELF_ID, xkcp_pkg::CSR_DATA_BITS'(self_id));
      if (spare) begin
         csr_write(CSR_SPARE_2, xkcp_pkg::CSR_DATA_BITS'($urandom));
         csr_write(CSR_SPARE_3, xkcp_pkg::CSR_DATA_BITS'($urandom));
      end
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [xkcp_pkg::ID_BITS-1:0] draw_peer_id();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 6) return self_id_reg;
      if (roll < 20) return xkcp_pkg::ID_BITS'($urandom);
      return id_pool[$urandom_range(POOL_SIZE-1)];
   endfunction

   function automatic peer_op_type draw_op(input int unsigned ins_pct,
                                           input int unsigned ers_pct);
      peer_op_type op;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < ins_pct) op.kind = xkcp_pkg::KIND_INSERT;
      else if (roll < ins_pct + ers_pct) op.kind = xkcp_pkg::KIND_ERASE;
      else op.kind = xkcp_pkg::KIND_QUERY;
      op.peer_id   = draw_peer_id();
      op.peer_addr = xkcp_pkg::ADDR_BITS'($urandom);
      roll = $urandom_range(3);
      if (roll < 2) op.key = xkcp_pkg::ID_BITS'($urandom);
      else op.key = id_pool[$urandom_range(POOL_SIZE-1)];
      if (roll == 3)
         op.key = op.key ^ (xkcp_pkg::ID_BITS'(1) << $urandom_range(xkcp_pkg::ID_BITS-1));
      return op;
   endfunction

   task automatic run_phase(input logic [xkcp_pkg::K_BEST_BITS-1:0] k,
                            input logic [xkcp_pkg::ID_BITS-1:0] self_id,
                            input logic spare, input int unsigned gap_pct,
                            input int unsigned stall_pct, input int unsigned count,
                            input int unsigned ins_pct, input int unsigned ers_pct);
      peer_op_type op;
      configure(k, self_id, spare);
      req_gap_pct = gap_pct;
      rsp_stall_pct <= stall_pct;
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(99) < 3) begin
            op = draw_op(ins_pct, ers_pct);
            op.kind = KIND_NONE;
            send_op(op, 1'b0, '0);
         end
         send_op(draw_op(ins_pct, ers_pct), 1'b0, '0);
      end
      settle();
   endtask

   task automatic add_row(input logic [xkcp_pkg::KIND_BITS-1:0] kind,
                          input logic [xkcp_pkg::ID_BITS-1:0] id,
                          input logic [xkcp_pkg::ADDR_BITS-1:0] addr,
                          input logic [xkcp_pkg::ID_BITS-1:0] key,
                          input logic typed, input logic [xkcp_pkg::ID_BITS-1:0] want_id,
                          input logic [xkcp_pkg::ADDR_BITS-1:0] want_addr,
                          input xkcp_pkg::status_type want_status);
      directed_row_type row;
      row.op     = '{kind, id, addr, key};
      row.typed  = typed;
      row.result = '{want_id, want_addr, '0, want_status, 1'b1};
      directed_rows.insert(directed_rows.size(), row);
   endtask

   initial begin : rsp_holdoff
      rsp_hold <= 1'b0;
      wait (holdoff_req === 1'b1);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin : rsp_monitor
      peer_result_type want;
      fail_count      = 0;
      results_checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results_checked++;
            status_seen[rsp_ch.status]++;
            if (due_results.size() == 0) begin
               $error("unexpected result transaction: id %h status %0d",
                      rsp_ch.result_id, rsp_ch.status);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_ch.result_id !== want.id) begin
                  $error("result_id: expected %h, got %h", want.id, rsp_ch.result_id);
                  fail_count++;
               end
               if (rsp_ch.result_addr !== want.addr) begin
                  $error("result_addr: expected %h, got %h", want.addr, rsp_ch.result_addr);
                  fail_count++;
               end
               if (rsp_ch.result_distance !== want.distance) begin
                  $error("result_distance: expected %h, got %h", want.distance,
                         rsp_ch.result_distance);
                  fail_count++;
               end
               if (rsp_ch.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                  fail_count++;
               end
               if (rsp_ch.last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_ch.last);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("xor_k_closest_peer_table verification failed");
      $finish;
   end

   initial begin : stimulus
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.kind      <= xkcp_pkg::KIND_INSERT;
      req_ch.peer_id   <= '0;
      req_ch.peer_addr <= '0;
      req_ch.key       <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= xkcp_pkg::CSR_K_BEST;
      csr_ch.data      <= '0;
      rsp_stall_pct    <= 0;
      holdoff_req      <= 1'b0;
      req_gap_pct  = 0;
      ops_accepted = 0;
      k_best_reg   = xkcp_pkg::K_BEST_RESET;
      self_id_reg  = '0;
      foreach (peer_live[s]) peer_live[s] = 1'b0;
      id_pool[0] = '0;
      id_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = xkcp_pkg::ID_BITS'($urandom);

      add_row(xkcp_pkg::KIND_QUERY,  16'h0000, 10'h000, 16'h0000,
              1, 16'h0000, 10'h000, xkcp_pkg::STAT_EMPTY);
      add_row(xkcp_pkg::KIND_ERASE,  16'h1234, 10'h3ff, 16'h0000,
              1, 16'h1234, 10'h000, xkcp_pkg::STAT_MISS);
      add_row(xkcp_pkg::KIND_INSERT, 16'h0000, 10'h3ff, 16'h0000,
              1, 16'h0000, 10'h3ff, xkcp_pkg::STAT_SELF);
      add_row(xkcp_pkg::KIND_INSERT, 16'hffff, 10'h3ff, 16'h0000,
              1, 16'hffff, 10'h3ff, xkcp_pkg::STAT_INSERTED);
      add_row(xkcp_pkg::KIND_INSERT, 16'h0001, 10'h000, 16'hffff,
              1, 16'h0001, 10'h000, xkcp_pkg::STAT_INSERTED);
      add_row(xkcp_pkg::KIND_INSERT, 16'h8000, 10'h155, 16'h0000,
              1, 16'h8000, 10'h155, xkcp_pkg::STAT_INSERTED);
      add_row(xkcp_pkg::KIND_INSERT, 16'h7fff, 10'h2aa, 16'h0000,
              1, 16'h7fff, 10'h2aa, xkcp_pkg::STAT_INSERTED);
      add_row(xkcp_pkg::KIND_INSERT, 16'hffff, 10'h001, 16'h0000,
              1, 16'hffff, 10'h001, xkcp_pkg::STAT_UPDATED);
      add_row(xkcp_pkg::KIND_QUERY,  16'h0000, 10'h000, 16'hffff,
              0, 16'h0000, 10'h000, xkcp_pkg::STAT_PEER);
      add_row(xkcp_pkg::KIND_QUERY,  16'hffff, 10'h3ff, 16'h0000,
              0, 16'h0000, 10'h000, xkcp_pkg::STAT_PEER);
      add_row(KIND_NONE,             16'hffff, 10'h3ff, 16'hffff,
              0, 16'h0000, 10'h000, xkcp_pkg::STAT_PEER);
      add_row(xkcp_pkg::KIND_ERASE,  16'h8000, 10'h2aa, 16'h0000,
              1, 16'h8000, 10'h000, xkcp_pkg::STAT_ERASED);
      add_row(xkcp_pkg::KIND_ERASE,  16'h8000, 10'h000, 16'h0000,
              1, 16'h8000, 10'h000, xkcp_pkg::STAT_MISS);
      add_row(xkcp_pkg::KIND_QUERY,  16'h0000, 10'h000, 16'h8000,
              0, 16'h0000, 10'h000, xkcp_pkg::STAT_PEER);
      add_row(xkcp_pkg::KIND_INSERT, 16'h5555, 10'h0aa, 16'h0000,
              1, 16'h5555, 10'h0aa, xkcp_pkg::STAT_INSERTED);
      add_row(xkcp_pkg::KIND_QUERY,  16'h0000, 10'h000, 16'haaaa,
              0, 16'h0000, 10'h000, xkcp_pkg::STAT_PEER);
      add_row(xkcp_pkg::KIND_INSERT, 16'haaaa, 10'h3ff, 16'h0000,
              1, 16'haaaa, 10'h3ff, xkcp_pkg::STAT_INSERTED);
      add_row(xkcp_pkg::KIND_QUERY,  16'h0000, 10'h000, 16'h5555,
              0, 16'h0000, 10'h000, xkcp_pkg::STAT_PEER);
      add_row(KIND_NONE,             16'h0000, 10'h000, 16'h0000,
              0, 16'h0000, 10'h000, xkcp_pkg::STAT_PEER);
      add_row(xkcp_pkg::KIND_ERASE,  16'h0001, 10'h000, 16'h0000,
              1, 16'h0001, 10'h000, xkcp_pkg::STAT_ERASED);
      add_row(xkcp_pkg::KIND_QUERY,  16'h0000, 10'h000, 16'h1234,
              0, 16'h0000, 10'h000, xkcp_pkg::STAT_PEER);
      add_row(xkcp_pkg::KIND_ERASE,  16'hffff, 10'h000, 16'h0000,
              1, 16'hffff, 10'h000, xkcp_pkg::STAT_ERASED);
      add_row(xkcp_pkg::KIND_QUERY,  16'h0000, 10'h000, 16'h7fff,
              0, 16'h0000, 10'h000, xkcp_pkg::STAT_PEER);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].result);
      settle();

      run_phase(5'd1,  16'hffff,                     0, 0,  0,  60,  50, 20);
      // Mostly inserts over a pool larger than the table, so the table fills up.
      run_phase(5'd20, xkcp_pkg::ID_BITS'($urandom), 0, 45, 0,  120, 90, 4);
      run_phase(5'd0,  xkcp_pkg::ID_BITS'($urandom), 1, 0,  45, 60,  30, 20);
      run_phase(5'd31, 16'h0000,                     0, 38, 38, 80,  40, 20);
      // The result side holds off for a long stretch while requests keep coming.
      holdoff_req <= 1'b1;
      run_phase(5'd7,  xkcp_pkg::ID_BITS'($urandom), 0, 0,  0,  30,  40, 20);
      run_phase(xkcp_pkg::K_BEST_BITS'($urandom_range(1, 31)), xkcp_pkg::ID_BITS'($urandom),
                1, 38, 38, 60, 20, 50);
      run_phase(5'd20, id_pool[5],                   0, 0,  45, 70,  45, 15);

      $display("Covered %0d operations and %0d result transactions over seven register settings.",
               ops_accepted, results_checked);
      $display("Inserted %0d, updated %0d, dropped full %0d, erased %0d, missed %0d, %s",
               status_seen[xkcp_pkg::STAT_INSERTED], status_seen[xkcp_pkg::STAT_UPDATED],
               status_seen[xkcp_pkg::STAT_FULL], status_seen[xkcp_pkg::STAT_ERASED],
               status_seen[xkcp_pkg::STAT_MISS],
               $sformatf("empty %0d, self %0d.", status_seen[xkcp_pkg::STAT_EMPTY],
                         status_seen[xkcp_pkg::STAT_SELF]));
      if (fail_count == 0) begin
         $display("xor_k_closest_peer_table verification clean");
      end else begin
         $display("xor_k_closest_peer_table verification failed");
      end
      $finish;
   end

endmodule
